// ===== hdl/mep_pkg.sv =====
// ----------------------------------------------------------------------------
// mep_pkg
// Shared widths, reset values, register indexes and types for the
// escape-time pixel evaluator.
// ----------------------------------------------------------------------------
package mep_pkg;

  // default image geometry
  localparam int IMAGE_WIDTH_DEF  = 1024;
  localparam int IMAGE_HEIGHT_DEF = 1024;

  // field and datapath widths
  localparam int COORD_W    = 10;
  localparam int COUNT_W    = 10;
  localparam int STEP_W     = 25;
  localparam int Q_W        = 32;
  localparam int Q_FRAC     = 24;
  localparam int MUL_W      = 32;
  localparam int COLOR_W    = 8;
  localparam int T_W        = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // register reset values
  localparam logic [Q_W-1:0]     CENTER_RE_RST = 32'hFF40_0000;  // -0.75
  localparam logic [Q_W-1:0]     CENTER_IM_RST = 32'h0000_0000;
  localparam logic [STEP_W-1:0]  STEP_RST      = 25'h000_4000;
  localparam logic [COUNT_W-1:0] MAX_ITER_RST  = 10'd250;

  // escape radius squared, 4.0 in Q8.24
  localparam logic [Q_W-1:0] ESCAPE_LIMIT = 32'h0400_0000;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CENTER_RE = 3'd0,
    CFG_CENTER_IM = 3'd1,
    CFG_STEP_RE   = 3'd2,
    CFG_STEP_IM   = 3'd3,
    CFG_MAX_ITER  = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
  } rgb_t;

  // status from the colour unit back to the sequencer
  typedef struct packed {
    logic done;
    rgb_t rgb;
  } color_res_t;

endpackage

// ===== hdl/mep_mul.sv =====
// ----------------------------------------------------------------------------
// mep_mul
// Shared unsigned multiplier with a registered product, used for the
// coordinate mapping and for every square of the iteration.
// ----------------------------------------------------------------------------
module mep_mul (
  input  logic                           clk_i,
  input  logic [mep_pkg::MUL_W-1:0]      a_i,
  input  logic [mep_pkg::MUL_W-1:0]      b_i,
  output logic [2*mep_pkg::MUL_W-1:0]    prod_o
);

  logic [2*mep_pkg::MUL_W-1:0] prod_q;

  // one product per cycle, registered
  always_ff @(posedge clk_i) begin
    prod_q <= (2*mep_pkg::MUL_W)'(a_i) * (2*mep_pkg::MUL_W)'(b_i);
  end

  assign prod_o = prod_q;

endmodule

// ===== hdl/mep_color.sv =====
// ----------------------------------------------------------------------------
// mep_color
// Colour unit: restoring divide of count by the limit (one quotient bit per
// cycle), bit-serial square root of the Q0.32 ratio, then the four-segment
// blue-cyan-green-yellow-red ramp.
// ----------------------------------------------------------------------------
module mep_color (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [mep_pkg::COUNT_W-1:0]   count_i,
  input  logic [mep_pkg::COUNT_W-1:0]   max_i,
  output mep_pkg::color_res_t           res_o
);

  localparam int QuoW = 32;
  localparam int StepW = $clog2(QuoW);
  localparam logic [9:0] RampGain = 10'd1020;

  typedef enum logic [3:0] {
    C_IDLE = 4'b0001,
    C_DIV  = 4'b0010,
    C_SQRT = 4'b0100,
    C_RAMP = 4'b1000
  } cstate_e;

  cstate_e state_q, state_d;

  logic [StepW-1:0]            step_q;
  logic [mep_pkg::COUNT_W-1:0] rem_q;
  logic [mep_pkg::COUNT_W-1:0] div_q;
  logic [QuoW-1:0]             quo_q;
  logic [QuoW-1:0]             rad_q;
  logic [QuoW-1:0]             root_q;
  logic [QuoW-1:0]             bit_q;

  // divide step
  logic [mep_pkg::COUNT_W:0]   rem_sh;
  logic                        div_ge;
  logic [mep_pkg::COUNT_W:0]   rem_sub;

  // square root step
  logic [QuoW:0]               sq_trial;
  logic                        sq_ge;

  assign rem_sh  = {rem_q, 1'b0};
  assign div_ge  = rem_sh >= {1'b0, div_q};
  assign rem_sub = rem_sh - {1'b0, div_q};

  assign sq_trial = {1'b0, root_q} + {1'b0, bit_q};
  assign sq_ge    = {1'b0, rad_q} >= sq_trial;

  // ramp from t in Q0.16
  function automatic mep_pkg::rgb_t ramp(logic [mep_pkg::T_W-1:0] t);
    logic [13:0]   d;
    logic [23:0]   p;
    logic [24:0]   pc;
    logic [7:0]    up;
    logic [7:0]    dn;
    mep_pkg::rgb_t c;
    d  = t[13:0];
    p  = 24'(d) * 24'(RampGain);
    pc = {1'b0, p} + 25'h00_FFFF;
    up = p[23:16];
    dn = 8'hFF - pc[23:16];
    unique case (t[15:14])
      2'b00: begin
        c.red = 8'h00; c.green = up;    c.blue = 8'hFF;
      end
      2'b01: begin
        c.red = 8'h00; c.green = 8'hFF; c.blue = dn;
      end
      2'b10: begin
        c.red = up;    c.green = 8'hFF; c.blue = 8'h00;
      end
      default: begin
        c.red = 8'hFF; c.green = dn;    c.blue = 8'h00;
      end
    endcase
    return c;
  endfunction

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      C_IDLE: if (start_i) state_d = C_DIV;
      C_DIV:  if (step_q == StepW'(QuoW - 1)) state_d = C_SQRT;
      C_SQRT: if (bit_q[0]) state_d = C_RAMP;
      C_RAMP: state_d = C_IDLE;
      default: state_d = C_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= C_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // divide and root datapath
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      C_IDLE: begin
        rem_q  <= count_i;
        div_q  <= max_i;
        step_q <= '0;
        quo_q  <= '0;
      end
      C_DIV: begin
        rem_q  <= div_ge ? rem_sub[mep_pkg::COUNT_W-1:0] : rem_sh[mep_pkg::COUNT_W-1:0];
        quo_q  <= {quo_q[QuoW-2:0], div_ge};
        step_q <= step_q + 1'b1;
        rad_q  <= {quo_q[QuoW-2:0], div_ge};
        root_q <= '0;
        bit_q  <= QuoW'(1) << (QuoW - 2);
      end
      C_SQRT: begin
        if (sq_ge) begin
          rad_q  <= rad_q - sq_trial[QuoW-1:0];
          root_q <= (root_q >> 1) + bit_q;
        end else begin
          root_q <= root_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
      default: begin
      end
    endcase
  end

  assign res_o.done = (state_q == C_RAMP);
  assign res_o.rgb  = ramp(root_q[mep_pkg::T_W-1:0]);

endmodule

// ===== hdl/mandelbrot_escape_pixel.sv =====
// ----------------------------------------------------------------------------
// mandelbrot_escape_pixel
// Escape-time evaluator for one pixel: maps the pixel to a point c in
// Q8.24, iterates z = z^2 + c in the three-square form on one shared
// multiplier, and returns the count, the inside flag and a ramp colour.
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+------------------------------
//  in      | input     | in_valid_i / in_ready_o | pixel_col_i, pixel_row_i
//  out     | output    | out_valid_o / out_ready_i | iteration_count_o, inside_set_o,
//          |           |                        | red_o, green_o, blue_o
//  cfg     | input     | cfg_we_i (no wait)     | cfg_idx_i, cfg_data_i
//
//  Points outside the set also pass through the divide and square root of
//  the colour unit before the result. Each iteration is a loop test, three
//  squares on the one multiplier and a write-back; the sequencer returns to
//  idle, ready for the next beat, when the result enters the output register.
//  A stalled output holds the sequencer in its done state.
//  Reset restores the register defaults and empties the output register.
// ----------------------------------------------------------------------------
module mandelbrot_escape_pixel #(
  parameter int IMAGE_WIDTH  = mep_pkg::IMAGE_WIDTH_DEF,
  parameter int IMAGE_HEIGHT = mep_pkg::IMAGE_HEIGHT_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // configuration writes
  input  logic                             cfg_we_i,
  input  logic [mep_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [mep_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  // pixel input
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [mep_pkg::COORD_W-1:0]      pixel_col_i,
  input  logic [mep_pkg::COORD_W-1:0]      pixel_row_i,
  // result output
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [mep_pkg::COUNT_W-1:0]      iteration_count_o,
  output logic                             inside_set_o,
  output logic [mep_pkg::COLOR_W-1:0]      red_o,
  output logic [mep_pkg::COLOR_W-1:0]      green_o,
  output logic [mep_pkg::COLOR_W-1:0]      blue_o
);

  localparam int QW    = mep_pkg::Q_W;
  localparam int MW    = mep_pkg::MUL_W;
  localparam int GeoW  = ($clog2(IMAGE_WIDTH) > $clog2(IMAGE_HEIGHT)) ?
                         $clog2(IMAGE_WIDTH) : $clog2(IMAGE_HEIGHT);
  // signed pixel offset width
  localparam int DW    = ((GeoW > mep_pkg::COORD_W) ? GeoW : mep_pkg::COORD_W) + 2;
  // mapping sum width
  localparam int MapW  = DW + mep_pkg::STEP_W + 1;
  // iteration sum width
  localparam int SumW  = QW + 3;
  localparam int SqW   = QW - 1;
  localparam int SqLo  = mep_pkg::Q_FRAC;

  typedef enum logic [10:0] {
    S_IDLE   = 11'b000_0000_0001,
    S_MAP_RE = 11'b000_0000_0010,
    S_MAP_IM = 11'b000_0000_0100,
    S_MAP_FN = 11'b000_0000_1000,
    S_ITER   = 11'b000_0001_0000,
    S_SQ_X   = 11'b000_0010_0000,
    S_SQ_Y   = 11'b000_0100_0000,
    S_SQ_W   = 11'b000_1000_0000,
    S_SQ_WB  = 11'b001_0000_0000,
    S_COLOR  = 11'b010_0000_0000,
    S_DONE   = 11'b100_0000_0000
  } state_e;

  state_e state_q, state_d;

  // configuration registers
  logic [QW-1:0]                  center_re_q;
  logic [QW-1:0]                  center_im_q;
  logic [mep_pkg::STEP_W-1:0]     step_re_q;
  logic [mep_pkg::STEP_W-1:0]     step_im_q;
  logic [mep_pkg::COUNT_W-1:0]    max_iter_q;

  // pixel and iteration state
  logic [mep_pkg::COORD_W-1:0]    col_q;
  logic [mep_pkg::COORD_W-1:0]    row_q;
  logic [QW-1:0]                  cre_q;
  logic [QW-1:0]                  cim_q;
  logic [QW-1:0]                  x_q;
  logic [QW-1:0]                  y_q;
  logic [SqW-1:0]                 x2_q;
  logic [SqW-1:0]                 y2_q;
  logic [SqW-1:0]                 w_q;
  logic                           wovf_q;
  logic [mep_pkg::COUNT_W-1:0]    count_q;
  logic                           inside_q;
  mep_pkg::rgb_t                  rgb_q;

  // output register
  logic                           out_valid_q;
  logic [mep_pkg::COUNT_W-1:0]    out_count_q;
  logic                           out_inside_q;
  mep_pkg::rgb_t                  out_rgb_q;

  // datapath nets
  logic signed [DW-1:0]           dx;
  logic signed [DW-1:0]           dy;
  logic [DW-1:0]                  dx_mag;
  logic [DW-1:0]                  dy_mag;
  logic                           map_neg;
  logic [QW-1:0]                  map_ctr;
  logic [MapW-1:0]                map_mag;
  logic [MapW-1:0]                map_sum;
  logic [QW-1:0]                  map_sat;
  logic [SumW-1:0]                x_sum;
  logic [SumW-1:0]                y_sum;
  logic [QW:0]                    esc_sum;
  logic                           iter_go;
  logic                           at_limit;
  logic [QW-1:0]                  x_mag;
  logic [QW-1:0]                  y_mag;
  logic [QW:0]                    sxy;
  logic [QW:0]                    sxy_mag;
  logic [MW-1:0]                  mul_a;
  logic [MW-1:0]                  mul_b;
  logic [2*MW-1:0]                prod;
  logic                           sq_ovf;
  logic [SqW-1:0]                 sq_sat;
  logic                           color_start;
  mep_pkg::color_res_t            color_res;
  logic                           in_beat;
  logic                           out_load;

  // saturate a mapping sum to Q8.24
  function automatic logic [QW-1:0] sat_map(logic [MapW-1:0] v);
    if (!v[MapW-1] && (|v[MapW-2:QW-1])) begin
      return {1'b0, {(QW-1){1'b1}}};
    end else if (v[MapW-1] && !(&v[MapW-2:QW-1])) begin
      return {1'b1, {(QW-1){1'b0}}};
    end else begin
      return v[QW-1:0];
    end
  endfunction

  // saturate an iteration sum to Q8.24
  function automatic logic [QW-1:0] sat_it(logic [SumW-1:0] v);
    if (!v[SumW-1] && (|v[SumW-2:QW-1])) begin
      return {1'b0, {(QW-1){1'b1}}};
    end else if (v[SumW-1] && !(&v[SumW-2:QW-1])) begin
      return {1'b1, {(QW-1){1'b0}}};
    end else begin
      return v[QW-1:0];
    end
  endfunction

  assign in_beat  = in_valid_i && in_ready_o;
  assign out_load = (state_q == S_DONE) && (!out_valid_q || out_ready_i);

  // pixel offsets from the image center
  assign dx     = $signed(DW'(col_q)) - $signed(DW'(IMAGE_WIDTH / 2));
  assign dy     = $signed(DW'(IMAGE_HEIGHT / 2)) - $signed(DW'(row_q));
  assign dx_mag = dx[DW-1] ? (~dx + 1'b1) : dx;
  assign dy_mag = dy[DW-1] ? (~dy + 1'b1) : dy;

  // center plus signed offset product
  assign map_neg = (state_q == S_MAP_IM) ? dx[DW-1] : dy[DW-1];
  assign map_ctr = (state_q == S_MAP_IM) ? center_re_q : center_im_q;
  assign map_mag = {1'b0, prod[MapW-2:0]};
  assign map_sum = (map_neg ? (~map_mag + 1'b1) : map_mag) +
                   {{(MapW-QW){map_ctr[QW-1]}}, map_ctr};
  assign map_sat = sat_map(map_sum);

  // next z from the three squares
  assign x_sum = {4'b0, x2_q} - {4'b0, y2_q} + {{3{cre_q[QW-1]}}, cre_q};
  assign y_sum = {4'b0, w_q} - {4'b0, x2_q} - {4'b0, y2_q} +
                 {{3{cim_q[QW-1]}}, cim_q};

  // loop test
  assign esc_sum  = {2'b0, x2_q} + {2'b0, y2_q};
  assign at_limit = (count_q >= max_iter_q);
  assign iter_go  = (esc_sum <= {1'b0, mep_pkg::ESCAPE_LIMIT}) && !at_limit;

  // square operands
  assign x_mag   = x_q[QW-1] ? (~x_q + 1'b1) : x_q;
  assign y_mag   = y_q[QW-1] ? (~y_q + 1'b1) : y_q;
  assign sxy     = {x_q[QW-1], x_q} + {y_q[QW-1], y_q};
  assign sxy_mag = sxy[QW] ? (~sxy + 1'b1) : sxy;

  // multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      S_MAP_RE: begin
        mul_a = MW'(dx_mag);
        mul_b = MW'(step_re_q);
      end
      S_MAP_IM: begin
        mul_a = MW'(dy_mag);
        mul_b = MW'(step_im_q);
      end
      S_SQ_X: begin
        mul_a = x_mag;
        mul_b = x_mag;
      end
      S_SQ_Y: begin
        mul_a = y_mag;
        mul_b = y_mag;
      end
      S_SQ_W: begin
        mul_a = sxy_mag[MW-1:0];
        mul_b = sxy_mag[MW-1:0];
      end
      default: begin
      end
    endcase
  end

  mep_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  // square scaled to Q8.24 and clipped to the positive range
  assign sq_ovf = (state_q == S_SQ_WB) && wovf_q;
  assign sq_sat = (sq_ovf || (|prod[2*MW-1:SqLo+SqW])) ? {SqW{1'b1}} :
                  prod[SqLo+SqW-1:SqLo];

  assign color_start = (state_q == S_ITER) && !iter_go && !at_limit;

  mep_color u_color (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (color_start),
    .count_i (count_q),
    .max_i   (max_iter_q),
    .res_o   (color_res)
  );

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:   if (in_beat) state_d = S_MAP_RE;
      S_MAP_RE: state_d = S_MAP_IM;
      S_MAP_IM: state_d = S_MAP_FN;
      S_MAP_FN: state_d = S_ITER;
      S_ITER: begin
        if (iter_go) begin
          state_d = S_SQ_X;
        end else if (at_limit) begin
          state_d = S_DONE;
        end else begin
          state_d = S_COLOR;
        end
      end
      S_SQ_X:   state_d = S_SQ_Y;
      S_SQ_Y:   state_d = S_SQ_W;
      S_SQ_W:   state_d = S_SQ_WB;
      S_SQ_WB:  state_d = S_ITER;
      S_COLOR:  if (color_res.done) state_d = S_DONE;
      S_DONE:   if (out_load) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_re_q <= mep_pkg::CENTER_RE_RST;
      center_im_q <= mep_pkg::CENTER_IM_RST;
      step_re_q   <= mep_pkg::STEP_RST;
      step_im_q   <= mep_pkg::STEP_RST;
      max_iter_q  <= mep_pkg::MAX_ITER_RST;
    end else if (cfg_we_i) begin
      unique case (mep_pkg::cfg_idx_e'(cfg_idx_i))
        mep_pkg::CFG_CENTER_RE: center_re_q <= cfg_data_i[QW-1:0];
        mep_pkg::CFG_CENTER_IM: center_im_q <= cfg_data_i[QW-1:0];
        mep_pkg::CFG_STEP_RE:   step_re_q   <= cfg_data_i[mep_pkg::STEP_W-1:0];
        mep_pkg::CFG_STEP_IM:   step_im_q   <= cfg_data_i[mep_pkg::STEP_W-1:0];
        mep_pkg::CFG_MAX_ITER:  max_iter_q  <= cfg_data_i[mep_pkg::COUNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // pixel datapath
  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      col_q <= pixel_col_i;
      row_q <= pixel_row_i;
    end
    unique case (state_q)
      S_MAP_IM: cre_q <= map_sat;
      S_MAP_FN: begin
        cim_q   <= map_sat;
        x2_q    <= '0;
        y2_q    <= '0;
        w_q     <= '0;
        count_q <= '0;
      end
      S_ITER: begin
        if (iter_go) begin
          x_q     <= sat_it(x_sum);
          y_q     <= sat_it(y_sum);
          count_q <= count_q + 1'b1;
        end else begin
          inside_q <= at_limit;
          rgb_q    <= '0;
        end
      end
      S_SQ_Y: x2_q <= sq_sat;
      S_SQ_W: begin
        y2_q   <= sq_sat;
        wovf_q <= sxy_mag[QW];
      end
      S_SQ_WB: w_q <= sq_sat;
      S_COLOR: if (color_res.done) rgb_q <= color_res.rgb;
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_count_q  <= count_q;
      out_inside_q <= inside_q;
      out_rgb_q    <= rgb_q;
    end
  end

  assign in_ready_o        = (state_q == S_IDLE);
  assign out_valid_o       = out_valid_q;
  assign iteration_count_o = out_count_q;
  assign inside_set_o      = out_inside_q;
  assign red_o             = out_rgb_q.red;
  assign green_o           = out_rgb_q.green;
  assign blue_o            = out_rgb_q.blue;

endmodule

// ===== bench/tb_mandelbrot_escape_pixel.sv =====
// ----------------------------------------------------------------------------
// tb_mandelbrot_escape_pixel
// Self-checking bench for the escape-time pixel evaluator. Pixels are sent
// over the valid/ready input. A scoreboard predicts each pixel's count,
// inside flag and ramp colour from its own copy of the view registers.
// Every returned beat is compared field by field with the oldest
// prediction. Directed corner views come first, then random views, each
// loaded only while the block is idle.
// ----------------------------------------------------------------------------
module tb_mandelbrot_escape_pixel;
  timeunit 1ns;
  timeprecision 1ps;

  import mep_pkg::*;

  // Q8.24 limits and colour ramp breakpoints in Q0.16
  localparam int         Q_MAX           = 32'sh7FFF_FFFF;
  localparam int         Q_MIN           = 32'sh8000_0000;
  localparam bit [15:0]  T_QUARTER       = 16'd16384;
  localparam bit [15:0]  T_HALF          = 16'd32768;
  localparam bit [15:0]  T_THREE_QUARTER = 16'd49152;
  localparam bit [7:0]   COLOR_FULL      = 8'd255;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic               in_set;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
  } escape_result_t;

  // predicts escape results and checks returned beats in order
  class escape_tracker;
    int                 center_re;
    int                 center_im;
    bit [STEP_W-1:0]    step_re;
    bit [STEP_W-1:0]    step_im;
    bit [COUNT_W-1:0]   max_iter;
    escape_result_t     pending_pixels[$];
    int                 errors;

    function new();
      center_re = $signed(CENTER_RE_RST);
      center_im = $signed(CENTER_IM_RST);
      step_re   = STEP_RST;
      step_im   = STEP_RST;
      max_iter  = MAX_ITER_RST;
      errors    = 0;
    endfunction

    function void write_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_CENTER_RE: center_re = $signed(data);
        CFG_CENTER_IM: center_im = $signed(data);
        CFG_STEP_RE:   step_re   = data[STEP_W-1:0];
        CFG_STEP_IM:   step_im   = data[STEP_W-1:0];
        CFG_MAX_ITER:  max_iter  = data[COUNT_W-1:0];
        default: ;
      endcase
    endfunction

    function int sat_q(longint v);
      if (v > longint'(Q_MAX)) return Q_MAX;
      if (v < longint'(Q_MIN)) return Q_MIN;
      return int'(v);
    endfunction

    // exact square, floor shift to Q8.24, clipped to the positive max
    function int square_q(longint v);
      bit [63:0] mag;
      bit [63:0] prod;
      mag = (v < 0) ? 64'(-v) : 64'(v);
      if (mag > 64'hFFFF_FFFF) return Q_MAX;
      prod = (mag * mag) >> Q_FRAC;
      if (prod > 64'(Q_MAX)) return Q_MAX;
      return int'(prod);
    endfunction

    function bit [7:0] ramp_up(bit [15:0] d);
      return 8'((64'(d) * 64'd1020) >> 16);
    endfunction

    // falling edge truncates the real value, so subtract the ceiling
    function bit [7:0] ramp_down(bit [15:0] d);
      return 8'(64'd255 - ((64'(d) * 64'd1020 + 64'd65535) >> 16));
    endfunction

    function escape_result_t predict_pixel(logic [COORD_W-1:0] col,
                                           logic [COORD_W-1:0] row);
      escape_result_t res;
      longint         dx;
      longint         dy;
      int             c_re;
      int             c_im;
      int             zr;
      int             zi;
      int             zr2;
      int             zi2;
      int             zs2;
      int             iter;
      bit [63:0]      ratio;
      bit [15:0]      t;
      // pixel to point c
      dx   = longint'(col) - IMAGE_WIDTH_DEF / 2;
      dy   = IMAGE_HEIGHT_DEF / 2 - longint'(row);
      c_re = sat_q(longint'(center_re) + dx * longint'(step_re));
      c_im = sat_q(longint'(center_im) + dy * longint'(step_im));
      // three-square iteration from z = 0
      zr2  = 0;
      zi2  = 0;
      zs2  = 0;
      iter = 0;
      while (longint'(zr2) + longint'(zi2) <= longint'(ESCAPE_LIMIT) &&
             iter < int'(max_iter)) begin
        zr   = sat_q(longint'(zr2) - longint'(zi2) + longint'(c_re));
        zi   = sat_q(longint'(zs2) - longint'(zr2) - longint'(zi2) + longint'(c_im));
        zr2  = square_q(longint'(zr));
        zi2  = square_q(longint'(zi));
        zs2  = square_q(longint'(zr) + longint'(zi));
        iter++;
      end
      res.count  = iter[COUNT_W-1:0];
      res.in_set = (iter >= int'(max_iter));
      res.red    = '0;
      res.green  = '0;
      res.blue   = '0;
      // ramp colour from t = sqrt(count/max) in Q0.16
      if (!res.in_set) begin
        ratio = (64'(iter) << 32) / 64'(max_iter);
        t = '0;
        for (int k = T_W - 1; k >= 0; k--) begin
          t[k] = 1'b1;
          if (64'(t) * 64'(t) > ratio) t[k] = 1'b0;
        end
        if (t < T_QUARTER) begin
          res.green = ramp_up(t);
          res.blue  = COLOR_FULL;
        end else if (t < T_HALF) begin
          res.green = COLOR_FULL;
          res.blue  = ramp_down(t - T_QUARTER);
        end else if (t < T_THREE_QUARTER) begin
          res.red   = ramp_up(t - T_HALF);
          res.green = COLOR_FULL;
        end else begin
          res.red   = COLOR_FULL;
          res.green = ramp_down(t - T_THREE_QUARTER);
        end
      end
      return res;
    endfunction

    function void note_pixel(logic [COORD_W-1:0] col, logic [COORD_W-1:0] row);
      pending_pixels.push_back(predict_pixel(col, row));
    endfunction

    function int outstanding();
      return pending_pixels.size();
    endfunction

    function void check_pixel(logic [COUNT_W-1:0] count, logic in_set,
                              logic [COLOR_W-1:0] red, logic [COLOR_W-1:0] green,
                              logic [COLOR_W-1:0] blue);
      escape_result_t exp;
      if (pending_pixels.size() == 0) begin
        $error("result beat with no pixel outstanding, iteration_count %0d", count);
        errors++;
        return;
      end
      exp = pending_pixels.pop_front();
      if (exp.count !== count) begin
        $error("iteration_count: expected %0d, actual %0d", exp.count, count);
        errors++;
      end
      if (exp.in_set !== in_set) begin
        $error("inside_set: expected %0d, actual %0d", exp.in_set, in_set);
        errors++;
      end
      if (exp.red !== red) begin
        $error("red: expected %0d, actual %0d", exp.red, red);
        errors++;
      end
      if (exp.green !== green) begin
        $error("green: expected %0d, actual %0d", exp.green, green);
        errors++;
      end
      if (exp.blue !== blue) begin
        $error("blue: expected %0d, actual %0d", exp.blue, blue);
        errors++;
      end
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  in_valid_i;
  logic                  in_ready_o;
  logic [COORD_W-1:0]    pixel_col_i;
  logic [COORD_W-1:0]    pixel_row_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  logic [COUNT_W-1:0]    iteration_count_o;
  logic                  inside_set_o;
  logic [COLOR_W-1:0]    red_o;
  logic [COLOR_W-1:0]    green_o;
  logic [COLOR_W-1:0]    blue_o;

  escape_tracker tracker;
  bit            quiet_mode = 1'b0;

  mandelbrot_escape_pixel #(
    .IMAGE_WIDTH (IMAGE_WIDTH_DEF),
    .IMAGE_HEIGHT(IMAGE_HEIGHT_DEF)
  ) dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .pixel_col_i      (pixel_col_i),
    .pixel_row_i      (pixel_row_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .iteration_count_o(iteration_count_o),
    .inside_set_o     (inside_set_o),
    .red_o            (red_o),
    .green_o          (green_o),
    .blue_o           (blue_o)
  );

  // 100 MHz clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // one pixel beat, valid held high across back-to-back beats
  task automatic send_pixel(input logic [COORD_W-1:0] col,
                            input logic [COORD_W-1:0] row);
    int unsigned gap;
    gap = quiet_mode ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    pixel_col_i <= col;
    pixel_row_i <= row;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    tracker.note_pixel(col, row);
  endtask

  // drop valid and let every outstanding pixel come back
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (tracker.outstanding() > 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // load all five view registers on consecutive cycles
  task automatic set_view(input logic [CFG_DATA_W-1:0] cre, input logic [CFG_DATA_W-1:0] cim,
                          input logic [CFG_DATA_W-1:0] sre, input logic [CFG_DATA_W-1:0] sim,
                          input logic [CFG_DATA_W-1:0] limit);
    cfg_idx_e              regs [5];
    logic [CFG_DATA_W-1:0] vals [5];
    regs = '{CFG_CENTER_RE, CFG_CENTER_IM, CFG_STEP_RE, CFG_STEP_IM, CFG_MAX_ITER};
    vals = '{cre, cim, sre, sim, limit};
    wait_idle();
    cfg_we_i <= 1'b1;
    foreach (regs[k]) begin
      cfg_idx_i  <= regs[k];
      cfg_data_i <= vals[k];
      @(posedge clk_i);
      tracker.write_reg(regs[k], vals[k]);
    end
    cfg_we_i <= 1'b0;
  endtask

  // result side with random back-pressure
  initial begin : result_sink
    int unsigned stall;
    out_ready_i <= 1'b0;
    do @(posedge clk_i); while (rst_ni !== 1'b1);
    forever begin
      stall = quiet_mode ? 0 : $urandom_range(0, 9);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (out_valid_o !== 1'b1);
      tracker.check_pixel(iteration_count_o, inside_set_o, red_o, green_o, blue_o);
    end
  end

  // main stimulus
  initial begin : stimulus
    int          c_re;
    int          c_im;
    int unsigned step_x;
    int unsigned step_y;
    int unsigned limit;
    int unsigned n_items;
    tracker     = new();
    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= CFG_CENTER_RE;
    cfg_data_i  <= '0;
    in_valid_i  <= 1'b0;
    pixel_col_i <= '0;
    pixel_row_i <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // default view after reset: corners, center, alternating bits
    send_pixel(10'd0, 10'd0);
    send_pixel(10'd1023, 10'd1023);
    send_pixel(10'd1023, 10'd0);
    send_pixel(10'd0, 10'd1023);
    send_pixel(10'd512, 10'd512);
    send_pixel(10'h2AA, 10'h155);
    send_pixel(10'h155, 10'h2AA);

    // unit step around the origin, full limit: c = 0 never escapes
    set_view(32'h0000_0000, 32'h0000_0000, 32'h0100_0000, 32'h0100_0000, 32'd1023);
    send_pixel(10'd512, 10'd512);
    send_pixel(10'd513, 10'd512);
    send_pixel(10'd511, 10'd512);
    send_pixel(10'd0, 10'd1023);
    send_pixel(10'd1023, 10'd0);

    // extreme centers, mapping and squares saturate
    set_view(32'h7FFF_FFFF, 32'h8000_0000, 32'h0100_0000, 32'h0100_0000, 32'd7);
    send_pixel(10'd1023, 10'd1023);
    send_pixel(10'd0, 10'd0);
    send_pixel(10'd512, 10'd512);

    // zero limit: nothing iterates, every point black
    set_view(32'hFF40_0000, 32'h0000_0000, 32'h0000_4000, 32'h0000_4000, 32'd0);
    send_pixel(10'd512, 10'd512);
    send_pixel(10'd0, 10'd1023);

    // zero step: every pixel maps onto the center
    set_view(32'hFF40_0000, 32'h0019_9999, 32'h0000_0000, 32'h0000_0000, 32'd20);
    send_pixel(10'd0, 10'd0);
    send_pixel(10'd1023, 10'd1023);
    send_pixel(10'd1023, 10'd0);

    // smallest step and a limit of one
    set_view(32'h0000_0000, 32'h0000_0000, 32'h0000_0001, 32'h0000_0001, 32'd1);
    send_pixel(10'd700, 10'd300);

    // random views, mostly near the set, one with the full limit
    for (int ph = 0; ph < 9; ph++) begin
      if ($urandom_range(0, 4) == 0) begin
        c_re = $urandom;
        c_im = $urandom;
      end else begin
        c_re = int'($urandom_range(0, 50331648)) - 37748736;
        c_im = int'($urandom_range(0, 41943040)) - 20971520;
      end
      step_x = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 1 << 24)
                                           : $urandom_range(1 << 8, 1 << 16);
      step_y = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 1 << 24)
                                           : $urandom_range(1 << 8, 1 << 16);
      limit   = (ph == 5) ? 1023 : $urandom_range(1, 120);
      n_items = (limit > 300) ? 12 : 55;
      set_view(c_re, c_im, step_x, step_y, limit);
      quiet_mode = (ph % 3 == 1);
      repeat (n_items) begin
        if ($urandom_range(0, 39) == 0) wait_idle();
        send_pixel(COORD_W'($urandom_range(0, 1023)), COORD_W'($urandom_range(0, 1023)));
      end
      quiet_mode = 1'b0;
    end

    // drain and watch for stray beats
    wait_idle();
    repeat (300) @(posedge clk_i);
    if (tracker.errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  // run limit, 100 ms
  initial begin : watchdog
    #100_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// ===== mandelbrot_escape_pixel.f =====
hdl/mep_pkg.sv
hdl/mep_mul.sv
hdl/mep_color.sv
hdl/mandelbrot_escape_pixel.sv
bench/tb_mandelbrot_escape_pixel.sv
